### design/spq_pkg.sv
package spq_pkg;

  // Default pool size
  localparam int unsigned QueueDepthDef = 16;

  // Width of the occupancy result field
  localparam int unsigned OccW = 5;

  // Action codes
  localparam logic ActPush = 1'b0;
  localparam logic ActPop  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One command item
  typedef struct packed {
    logic               action;
    logic [1:0]         prio;
    logic signed [7:0]  receiver_id;
    logic signed [7:0]  sender_id;
    logic [7:0]         kind;
    logic [31:0]        payload_word;
    logic [7:0]         tag;
    logic [31:0]        data_handle;
    logic [31:0]        callback_handle;
  } cmd_t;

  // One result item
  typedef struct packed {
    status_e            status;
    logic [1:0]         out_prio;
    logic signed [7:0]  out_receiver;
    logic signed [7:0]  out_sender;
    logic [7:0]         out_kind;
    logic [31:0]        out_payload;
    logic [7:0]         out_tag;
    logic [31:0]        out_data_handle;
    logic [31:0]        out_callback_handle;
    logic [OccW-1:0]    occupancy;
  } res_t;

  // Stored event
  typedef struct packed {
    logic [1:0]         prio;
    logic signed [7:0]  receiver_id;
    logic signed [7:0]  sender_id;
    logic [7:0]         kind;
    logic [31:0]        payload_word;
    logic [7:0]         tag;
    logic [31:0]        data_handle;
    logic [31:0]        callback_handle;
  } entry_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic       push;
    logic       pop;
    entry_t     entry;
  } cell_ctrl_t;

  // What a cell hands to its right neighbor
  typedef struct packed {
    logic       gt;
    entry_t     entry;
  } cell_link_t;

endpackage

### design/stable_priority_event_queue.sv
// An accepted item gives its result with done_o high in the next cycle.
// Throughput: one item per cycle; busy stays low, every cell of the row updates together.
// Results show for exactly one cycle; the receiver cannot stall.
// Reset (rst_ni low, asynchronous): fill count cleared, no result pending;
// entry storage is not cleared and is only read below the fill count.
module stable_priority_event_queue import spq_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  cmd_t cmd_i,
  output logic done_o,
  output res_t res_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  res_t            res_q, res_d;
  logic            accept, full, empty;
  cell_ctrl_t      ctrl;
  entry_t          new_entry;
  cell_link_t      links [QueueDepth];
  logic [QueueDepth-1:0] valid;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(QueueDepth));
  assign empty  = (count_q == '0);

  // Item fields to a stored entry
  always_comb begin
    new_entry.prio            = cmd_i.prio;
    new_entry.receiver_id     = cmd_i.receiver_id;
    new_entry.sender_id       = cmd_i.sender_id;
    new_entry.kind            = cmd_i.kind;
    new_entry.payload_word    = cmd_i.payload_word;
    new_entry.tag             = cmd_i.tag;
    new_entry.data_handle     = cmd_i.data_handle;
    new_entry.callback_handle = cmd_i.callback_handle;
  end

  assign ctrl.push  = accept && (cmd_i.action == ActPush) && !full;
  assign ctrl.pop   = accept && (cmd_i.action == ActPop) && !empty;
  assign ctrl.entry = new_entry;

  // Cell row, cell 0 is the head
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    cell_link_t left;
    entry_t     right;

    assign valid[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_body
      assign left = links[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right = links[i].entry;
    end else begin : g_inner
      assign right = links[i+1].entry;
    end

    spq_cell u_cell (
      .clk_i   (clk_i),
      .valid_i (valid[i]),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .link_o  (links[i])
    );
  end

  // Fill count and result word
  always_comb begin
    count_d = count_q;
    if (ctrl.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - CntW'(1);
    end

    res_d           = '0;
    res_d.status    = ST_OK;
    res_d.occupancy = OccW'(count_d);
    if (cmd_i.action == ActPush) begin
      if (full) begin
        res_d.status = ST_FULL;
      end
    end else if (empty) begin
      res_d.status = ST_EMPTY;
    end else begin
      res_d.out_prio            = links[0].entry.prio;
      res_d.out_receiver        = links[0].entry.receiver_id;
      res_d.out_sender          = links[0].entry.sender_id;
      res_d.out_kind            = links[0].entry.kind;
      res_d.out_payload         = links[0].entry.payload_word;
      res_d.out_tag             = links[0].entry.tag;
      res_d.out_data_handle     = links[0].entry.data_handle;
      res_d.out_callback_handle = links[0].entry.callback_handle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Result payload holds no control state
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### design/spq_cell.sv
module spq_cell import spq_pkg::*; (
  input  logic       clk_i,
  input  logic       valid_i,
  input  cell_ctrl_t ctrl_i,
  input  cell_link_t left_i,
  input  entry_t     right_i,
  output cell_link_t link_o
);

  entry_t entry_q, entry_d;
  logic   gt;

  // Empty cells count as greater so a push lands at the end of the filled run
  assign gt = !valid_i || (entry_q.prio > ctrl_i.entry.prio);

  assign link_o.gt    = gt;
  assign link_o.entry = entry_q;

  // Insert here, shift right from the left neighbor, or shift left on pop
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      if (gt && !left_i.gt) begin
        entry_d = ctrl_i.entry;
      end else if (gt) begin
        entry_d = left_i.entry;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### design/spq_checker.sv
module spq_checker import spq_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input cmd_t cmd_i,
  input logic done_o,
  input res_t res_o
);

  // Every accepted item gets its result in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted item gave no result");

  // No result without an accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without an accepted item");

  // A push never reports an empty pool
  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.action == ActPush) |=> (res_o.status != ST_EMPTY))
    else $error("push reported empty status");

  // A rejected push reports a full pool
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_FULL) |-> (res_o.occupancy == OccW'(QueueDepth)))
    else $error("full status with wrong occupancy");

  // A pop of an empty pool reports zero entries
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_EMPTY) |-> (res_o.occupancy == '0))
    else $error("empty status with nonzero occupancy");

endmodule

bind stable_priority_event_queue spq_checker #(
  .QueueDepth (QueueDepth)
) u_spq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .cmd_i  (cmd_i),
  .done_o (done_o),
  .res_o  (res_o)
);
